@@ rtl/nth_regular_number_generator_macros.svh @@
// assertion macros shared by the regular number generator modules
`ifndef NTH_REGULAR_NUMBER_GENERATOR_MACROS_SVH
`define NTH_REGULAR_NUMBER_GENERATOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define NRG_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("nrg assertion failed");

// consequent that must hold in the cycle after the antecedent
`define NRG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrg sequence assertion failed");

`endif

@@ rtl/nrg_pkg.sv @@
// shared types and constants for the regular number generator
package nrg_pkg;

	localparam int POS_W = 13;
	localparam int VAL_W = 64;
	localparam int N_CAND = 3;

	// candidate slots
	localparam int SEL_TWO   = 0;
	localparam int SEL_THREE = 1;
	localparam int SEL_FIVE  = 2;

	// result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// seeds of the series
	localparam logic [VAL_W-1:0] SEED_ONE   = VAL_W'(1);
	localparam logic [VAL_W-1:0] SEED_TWO   = VAL_W'(2);
	localparam logic [VAL_W-1:0] SEED_THREE = VAL_W'(3);
	localparam logic [VAL_W-1:0] SEED_FIVE  = VAL_W'(5);

	typedef struct packed {
		logic load_pos;
		logic gen_wr;
		logic cand_rd;
		logic cand_upd;
		logic res_rd;
		logic out_load;
	} nrg_cmd_t;

	typedef struct packed {
		logic pos_err;
		logic need_gen;
		logic adv_more;
	} nrg_stat_t;

endpackage

@@ rtl/nrg_dpath.sv @@
// datapath of the regular number generator: series store, pointers, candidates
module nrg_dpath import nrg_pkg::*; #(
	parameter int SERIES_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [POS_W-1:0] position,
	input  nrg_cmd_t         cmd,
	output nrg_stat_t        stat,
	output logic [VAL_W-1:0] value,
	output logic             status
);

	localparam int AW = $clog2(SERIES_DEPTH);
	localparam int CW = $clog2(SERIES_DEPTH + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	logic [VAL_W-1:0] store_mem [SERIES_DEPTH];

	logic [POS_W-1:0]  pos_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     ptr_two_q, ptr_three_q, ptr_five_q;
	logic [VAL_W-1:0]  next_two_q, next_three_q, next_five_q;
	logic [N_CAND-1:0] adv_q, sel_q, sel_nxt, eq_min;
	logic [VAL_W-1:0]  rd_data_q;
	logic              rd_zero_q;
	logic [VAL_W-1:0]  value_q;
	logic              status_q;

	logic [VAL_W-1:0] min_val, rd_val, prod;
	logic [AW-1:0]    rd_ptr, rd_addr;
	logic [POS_W-1:0] pos_m1;
	logic             rd_en;

	// smallest candidate and which candidates equal it
	always_comb begin
		min_val = next_two_q;
		if (next_three_q < min_val) min_val = next_three_q;
		if (next_five_q < min_val) min_val = next_five_q;
		eq_min[SEL_TWO]   = (next_two_q == min_val);
		eq_min[SEL_THREE] = (next_three_q == min_val);
		eq_min[SEL_FIVE]  = (next_five_q == min_val);
	end

	// lowest pending candidate is refilled first
	always_comb begin
		sel_nxt = '0;
		if (adv_q[SEL_TWO]) sel_nxt[SEL_TWO] = 1'b1;
		else if (adv_q[SEL_THREE]) sel_nxt[SEL_THREE] = 1'b1;
		else if (adv_q[SEL_FIVE]) sel_nxt[SEL_FIVE] = 1'b1;
	end

	always_comb begin
		if (sel_nxt[SEL_TWO]) rd_ptr = ptr_two_q;
		else if (sel_nxt[SEL_THREE]) rd_ptr = ptr_three_q;
		else rd_ptr = ptr_five_q;
	end

	assign pos_m1  = pos_q - 1'b1;
	assign rd_addr = cmd.res_rd ? pos_m1[AW-1:0] : rd_ptr;
	assign rd_en   = cmd.res_rd | cmd.cand_rd;

	// entry zero is the seed and never written
	assign rd_val = rd_zero_q ? SEED_ONE : rd_data_q;

	always_comb begin
		if (sel_q[SEL_TWO]) prod = {rd_val[VAL_W-2:0], 1'b0};
		else if (sel_q[SEL_THREE]) prod = rd_val + {rd_val[VAL_W-2:0], 1'b0};
		else prod = rd_val + {rd_val[VAL_W-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (cmd.gen_wr) store_mem[count_q[AW-1:0]] <= min_val;
		if (rd_en) begin
			rd_data_q <= store_mem[rd_addr];
			rd_zero_q <= (rd_addr == '0);
		end
		if (cmd.load_pos) pos_q <= position;
		if (cmd.out_load) begin
			value_q  <= stat.pos_err ? '0 : rd_val;
			status_q <= stat.pos_err ? STATUS_RANGE : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= CW'(1);
			ptr_two_q    <= '0;
			ptr_three_q  <= '0;
			ptr_five_q   <= '0;
			next_two_q   <= SEED_TWO;
			next_three_q <= SEED_THREE;
			next_five_q  <= SEED_FIVE;
			adv_q        <= '0;
			sel_q        <= '0;
		end else begin
			if (cmd.gen_wr) begin
				count_q     <= count_q + 1'b1;
				adv_q       <= eq_min;
				ptr_two_q   <= ptr_two_q + AW'(eq_min[SEL_TWO]);
				ptr_three_q <= ptr_three_q + AW'(eq_min[SEL_THREE]);
				ptr_five_q  <= ptr_five_q + AW'(eq_min[SEL_FIVE]);
			end
			if (cmd.cand_rd) sel_q <= sel_nxt;
			if (cmd.cand_upd) begin
				adv_q <= adv_q & ~sel_q;
				if (sel_q[SEL_TWO]) next_two_q <= prod;
				if (sel_q[SEL_THREE]) next_three_q <= prod;
				if (sel_q[SEL_FIVE]) next_five_q <= prod;
			end
		end
	end

	assign stat.pos_err  = (pos_q == '0) || ((XW + 1)'(pos_q) > (XW + 1)'(SERIES_DEPTH));
	assign stat.need_gen = XW'(count_q) < XW'(pos_q);
	assign stat.adv_more = |(adv_q & ~sel_q);

	assign value  = value_q;
	assign status = status_q;

	`include "nth_regular_number_generator_macros.svh"

	`NRG_ASSERT(a_write_in_range, cmd.gen_wr |-> (XW'(count_q) < XW'(SERIES_DEPTH)))
	`NRG_ASSERT_NEXT(a_advance_taken, cmd.gen_wr, adv_q != '0)
	`NRG_ASSERT(a_refill_below_count, cmd.cand_rd |-> (CW'(rd_ptr) < count_q))

endmodule

@@ rtl/nrg_ctrl.sv @@
// controller state machine of the regular number generator
module nrg_ctrl import nrg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  nrg_stat_t stat,
	output nrg_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_GEN_WR   = 3'd2;
	localparam logic [2:0] S_CAND_RD  = 3'd3;
	localparam logic [2:0] S_CAND_UPD = 3'd4;
	localparam logic [2:0] S_RES_RD   = 3'd5;
	localparam logic [2:0] S_RESULT   = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_pos = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.pos_err) state_d = S_RESULT;
				else if (stat.need_gen) state_d = S_GEN_WR;
				else state_d = S_RES_RD;
			end
			S_GEN_WR: begin
				cmd.gen_wr = 1'b1;
				state_d    = S_CAND_RD;
			end
			S_CAND_RD: begin
				cmd.cand_rd = 1'b1;
				state_d     = S_CAND_UPD;
			end
			S_CAND_UPD: begin
				cmd.cand_upd = 1'b1;
				if (stat.adv_more) state_d = S_CAND_RD;
				else if (stat.need_gen) state_d = S_GEN_WR;
				else state_d = S_RES_RD;
			end
			S_RES_RD: begin
				cmd.res_rd = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`include "nth_regular_number_generator_macros.svh"

	`NRG_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_q || out_ready))
	`NRG_ASSERT_NEXT(a_gen_then_refill, cmd.gen_wr, cmd.cand_rd)
	`NRG_ASSERT_NEXT(a_transfer_checked, in_valid && in_ready, state_q == S_CHECK)

endmodule

@@ rtl/nth_regular_number_generator.sv @@
// Regular (5-smooth) number generator: one position in, one value and status out. A position
// already in the series store has its result presented after its input transfer through the
// steps check, one store read and output load. Otherwise the series is extended one element
// at a time, one store access at a time: each element is written, then for every pointer that
// advances (1 to 3) a candidate is read from the store and updated; the store read and output
// load follow. An out of range position (zero or above SERIES_DEPTH) returns value 0 with
// status 1 without a store read. A new position is taken once the previous result sits in the
// output register; a result waits there until it is taken. The store keeps its contents
// between requests and needs no clearing after reset.
module nth_regular_number_generator import nrg_pkg::*; #(
	parameter int SERIES_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [POS_W-1:0] position,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] value,
	output logic             status
);

	nrg_cmd_t  cmd;
	nrg_stat_t stat;

	nrg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nrg_dpath #(
		.SERIES_DEPTH (SERIES_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.position (position),
		.cmd      (cmd),
		.stat     (stat),
		.value    (value),
		.status   (status)
	);

endmodule
